[rtl/pbf_pkg.sv]
package pbf_pkg;

	// Sizing of the block
	localparam int PAGES       = 64;
	localparam int STORE_BYTES = 131072;
	localparam int MAX_HASHES  = 31;

	// Item field widths
	localparam int KIND_W = 2;
	localparam int PAGE_W = 6;
	localparam int KEY_W  = 32;
	localparam int BITS_W = 21;
	localparam int HASH_W = 5;
	localparam int BASE_W = 17;

	// Input tdata layout, lowest bit first
	localparam int IN_PAGE_LSB  = 0;
	localparam int IN_KEY_LSB   = IN_PAGE_LSB + PAGE_W;
	localparam int IN_BITS_LSB  = IN_KEY_LSB + KEY_W;
	localparam int IN_HASH_LSB  = IN_BITS_LSB + BITS_W;
	localparam int IN_BASE_LSB  = IN_HASH_LSB + HASH_W;
	localparam int IN_VALID_LSB = IN_BASE_LSB + BASE_W;
	localparam int IN_FIELDS_W  = IN_VALID_LSB + 1;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W   = 8;

	// Descriptor table row: {base, hash count, bits}
	localparam int DESC_W     = BASE_W + HASH_W + BITS_W;
	localparam int PAGE_IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

	// Bit store organized as 32-bit words
	localparam int WORD_W       = 32;
	localparam int WORD_SEL_W   = $clog2(WORD_W);
	localparam int STORE_BITS   = STORE_BYTES * 8;
	localparam int STORE_WORDS  = (STORE_BITS + WORD_W - 1) / WORD_W;
	localparam int STORE_ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	// Probe index and bit sum widths
	localparam int HASH_IDX_W = $clog2(MAX_HASHES + 1);
	localparam int SUM_W      = (((BASE_W + 3) > BITS_W) ? (BASE_W + 3) : BITS_W) + 1;

	// Remainder unit: two quotient bits a cycle over a 32-bit dividend
	localparam int DIV_BITS_PER_STEP = 2;
	localparam int DIV_STEPS         = KEY_W / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

	// Hash mixing constants
	localparam logic [31:0] MIX_C1 = 32'h2c1b3c6d;
	localparam logic [31:0] MIX_C2 = 32'h297a2d39;

	typedef logic [PAGE_IDX_W-1:0]   page_idx_t;
	typedef logic [STORE_ADDR_W-1:0] word_addr_t;
	typedef logic [HASH_IDX_W-1:0]   hash_idx_t;
	typedef logic [SUM_W-1:0]        sum_t;
	typedef logic [DIV_CNT_W-1:0]    div_cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DESC,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_ADDR,
		ST_RMW,
		ST_NEXT,
		ST_FIN
	} state_t;

endpackage

[rtl/pbf_ram.sv]
// Generic single write port, single read port RAM with registered read
module pbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/paged_bloom_filter_top.sv]
// Paged Bloom filter: one shared bit store split into per-page filters.
// Input channel s_*: tuser carries the kind (load descriptor, insert, query),
// tdata the page, key and descriptor fields. Output channel m_*: one result
// item per input item, tdata bit 0 present, bit 1 out_of_range.
// Items are handled one at a time. A descriptor load runs no probe. An insert
// or query runs k probes in turn (fewer when a query meets a clear bit early):
// each probe runs two registered multiplies of the hash, the shared remainder
// unit (2 bits a cycle), then one read and, for an insert, one write-back on
// the bit store port, both skipped for a probe outside the store. A page
// without a usable descriptor answers without any probe. After reset the bit
// store is cleared one 32-bit word a cycle, all STORE_WORDS words (32768 at
// the default size), with s_tready low; all descriptors start invalid. A
// finished result sits in an output register; while the receiver stalls the
// block still accepts the next item and works on it, and only holds that
// item's result until the output register frees up.
module paged_bloom_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// page, key, page_bits, hash_count, page_base, page_valid, zero pad
	input  logic [pbf_pkg::IN_DATA_W-1:0]   s_tdata,
	// kind
	input  logic [pbf_pkg::KIND_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// present, out_of_range, zero pad
	output logic [pbf_pkg::OUT_DATA_W-1:0]  m_tdata
);

	pbf_pkg::state_t state_q, state_nxt;

	// Item registers
	pbf_pkg::kind_t              kind_q;
	logic [pbf_pkg::PAGE_W-1:0]  page_q;
	logic [pbf_pkg::KEY_W-1:0]   key_q;
	logic [pbf_pkg::BITS_W-1:0]  bits_q;
	logic [pbf_pkg::BASE_W-1:0]  base_q;
	pbf_pkg::hash_idx_t          k_q;
	pbf_pkg::hash_idx_t          i_q;
	logic                        present_q;
	logic                        oor_q;

	// Hash and remainder registers
	logic [31:0]                 m1_q;
	logic [31:0]                 dvd_q;
	logic [pbf_pkg::BITS_W-1:0]  rem_q;
	pbf_pkg::div_cnt_t           div_cnt_q;
	pbf_pkg::word_addr_t         addr_q;
	logic [pbf_pkg::WORD_SEL_W-1:0] bit_q;

	// Descriptor valid flags and clearing counter
	logic [pbf_pkg::PAGES-1:0]   valid_q;
	pbf_pkg::word_addr_t         clr_q;

	// Output register
	logic                        out_valid_q;
	logic [pbf_pkg::OUT_DATA_W-1:0] out_data_q;

	// Memory ports
	logic                        tbl_we;
	logic                        tbl_re;
	logic [pbf_pkg::DESC_W-1:0]  tbl_wdata;
	logic [pbf_pkg::DESC_W-1:0]  tbl_rdata;
	logic                        st_we;
	logic                        st_re;
	pbf_pkg::word_addr_t         st_waddr;
	pbf_pkg::word_addr_t         st_raddr;
	logic [pbf_pkg::WORD_W-1:0]  st_wdata;
	logic [pbf_pkg::WORD_W-1:0]  st_rdata;
	logic                        out_load;

	// Input field views
	logic                        accept;
	pbf_pkg::kind_t              in_kind;
	logic [pbf_pkg::PAGE_W-1:0]  in_page;
	logic                        in_page_ok;

	assign accept     = s_tvalid & s_tready;
	assign in_kind    = pbf_pkg::kind_t'(s_tuser);
	assign in_page    = s_tdata[pbf_pkg::IN_PAGE_LSB +: pbf_pkg::PAGE_W];
	assign in_page_ok = (32'(in_page) < pbf_pkg::PAGES);

	// Descriptor decode from the table read
	logic [pbf_pkg::BITS_W-1:0]  d_bits;
	logic [pbf_pkg::HASH_W-1:0]  d_hash;
	logic [pbf_pkg::BASE_W-1:0]  d_base;
	pbf_pkg::hash_idx_t          d_k;
	logic                        page_ok;
	logic                        usable;

	assign d_bits  = tbl_rdata[pbf_pkg::BITS_W-1:0];
	assign d_hash  = tbl_rdata[pbf_pkg::BITS_W +: pbf_pkg::HASH_W];
	assign d_base  = tbl_rdata[pbf_pkg::BITS_W + pbf_pkg::HASH_W +: pbf_pkg::BASE_W];
	assign d_k     = (32'(d_hash) > pbf_pkg::MAX_HASHES) ?
		pbf_pkg::hash_idx_t'(pbf_pkg::MAX_HASHES) : pbf_pkg::hash_idx_t'(d_hash);
	assign page_ok = (32'(page_q) < pbf_pkg::PAGES);
	assign usable  = page_ok && valid_q[pbf_pkg::page_idx_t'(page_q)] && (d_bits != '0)
		&& ((kind_q == pbf_pkg::KIND_INSERT) || (kind_q == pbf_pkg::KIND_QUERY))
		&& (d_k != '0);

	// Hash mixing around the two multiplies
	logic [31:0] seed;
	logic [31:0] x1;
	logic [31:0] x2;
	logic [31:0] prod2;
	logic [31:0] x3;

	assign seed  = (key_q << 19) | (32'(i_q) << 7);
	assign x1    = seed ^ (seed >> 15);
	assign x2    = m1_q ^ (m1_q >> 12);
	assign prod2 = x2 * pbf_pkg::MIX_C2;
	assign x3    = prod2 ^ (prod2 >> 15);

	// Remainder unit step: two restoring steps a cycle
	logic [pbf_pkg::BITS_W:0]    div_r;
	logic [31:0]                 div_d;
	logic [pbf_pkg::BITS_W-1:0]  rem_nxt;
	logic [31:0]                 dvd_nxt;

	always_comb begin
		div_r = {1'b0, rem_q};
		div_d = dvd_q;
		for (int j = 0; j < pbf_pkg::DIV_BITS_PER_STEP; j++) begin
			div_r = {div_r[pbf_pkg::BITS_W-1:0], div_d[31]};
			div_d = {div_d[30:0], 1'b0};
			if (div_r >= {1'b0, bits_q}) begin
				div_r = div_r - {1'b0, bits_q};
			end
		end
		rem_nxt = div_r[pbf_pkg::BITS_W-1:0];
		dvd_nxt = div_d;
	end

	// Store bit address of the current probe
	pbf_pkg::sum_t bit_sum;
	logic [31:0]   bit_abs;
	logic          probe_oor;
	logic          bit_set;

	assign bit_sum   = pbf_pkg::sum_t'({base_q, 3'b000}) + pbf_pkg::sum_t'(rem_q);
	assign bit_abs   = 32'(bit_sum);
	assign probe_oor = (bit_abs >= 32'(pbf_pkg::STORE_BITS));
	assign bit_set   = st_rdata[bit_q];

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pbf_pkg::ST_CLEAR: begin
				if (clr_q == pbf_pkg::word_addr_t'(pbf_pkg::STORE_WORDS - 1)) begin
					state_nxt = pbf_pkg::ST_IDLE;
				end
			end
			pbf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = pbf_pkg::ST_DESC;
				end
			end
			pbf_pkg::ST_DESC: begin
				state_nxt = usable ? pbf_pkg::ST_MUL1 : pbf_pkg::ST_FIN;
			end
			pbf_pkg::ST_MUL1: state_nxt = pbf_pkg::ST_MUL2;
			pbf_pkg::ST_MUL2: state_nxt = pbf_pkg::ST_DIV;
			pbf_pkg::ST_DIV: begin
				if (div_cnt_q == pbf_pkg::div_cnt_t'(pbf_pkg::DIV_STEPS - 1)) begin
					state_nxt = pbf_pkg::ST_ADDR;
				end
			end
			pbf_pkg::ST_ADDR: begin
				state_nxt = probe_oor ? pbf_pkg::ST_NEXT : pbf_pkg::ST_RMW;
			end
			pbf_pkg::ST_RMW: begin
				if ((kind_q == pbf_pkg::KIND_QUERY) && !bit_set) begin
					state_nxt = pbf_pkg::ST_FIN;
				end else begin
					state_nxt = pbf_pkg::ST_NEXT;
				end
			end
			pbf_pkg::ST_NEXT: begin
				if ({1'b0, i_q} + 1'b1 == {1'b0, k_q}) begin
					state_nxt = pbf_pkg::ST_FIN;
				end else begin
					state_nxt = pbf_pkg::ST_MUL1;
				end
			end
			pbf_pkg::ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					state_nxt = pbf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pbf_pkg::ST_CLEAR;
		endcase
	end

	// Control outputs
	always_comb begin
		s_tready  = 1'b0;
		tbl_we    = 1'b0;
		tbl_re    = 1'b0;
		st_we     = 1'b0;
		st_re     = 1'b0;
		st_waddr  = addr_q;
		st_wdata  = st_rdata | (pbf_pkg::WORD_W'(1) << bit_q);
		out_load  = 1'b0;
		case (state_q)
			pbf_pkg::ST_CLEAR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				st_wdata = '0;
			end
			pbf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				tbl_re   = s_tvalid;
				tbl_we   = s_tvalid && (in_kind == pbf_pkg::KIND_LOAD) && in_page_ok;
			end
			pbf_pkg::ST_ADDR: begin
				st_re = !probe_oor;
			end
			pbf_pkg::ST_RMW: begin
				st_we = (kind_q == pbf_pkg::KIND_INSERT);
			end
			pbf_pkg::ST_FIN: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	assign tbl_wdata = {s_tdata[pbf_pkg::IN_BASE_LSB +: pbf_pkg::BASE_W],
		s_tdata[pbf_pkg::IN_HASH_LSB +: pbf_pkg::HASH_W],
		s_tdata[pbf_pkg::IN_BITS_LSB +: pbf_pkg::BITS_W]};
	assign st_raddr  = bit_abs[pbf_pkg::STORE_ADDR_W + pbf_pkg::WORD_SEL_W - 1 :
		pbf_pkg::WORD_SEL_W];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbf_pkg::ST_CLEAR;
			clr_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == pbf_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (tbl_we) begin
				valid_q[pbf_pkg::page_idx_t'(in_page)] <= s_tdata[pbf_pkg::IN_VALID_LSB];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			// probe and step counters
			if (state_q == pbf_pkg::ST_DESC) begin
				i_q <= '0;
			end else if (state_q == pbf_pkg::ST_NEXT) begin
				i_q <= i_q + 1'b1;
			end
			if (state_q == pbf_pkg::ST_MUL2) begin
				div_cnt_q <= '0;
			end else if (state_q == pbf_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			page_q <= in_page;
			key_q  <= s_tdata[pbf_pkg::IN_KEY_LSB +: pbf_pkg::KEY_W];
		end
		case (state_q)
			pbf_pkg::ST_DESC: begin
				bits_q    <= d_bits;
				base_q    <= d_base;
				k_q       <= d_k;
				present_q <= (kind_q == pbf_pkg::KIND_QUERY);
				oor_q     <= 1'b0;
			end
			pbf_pkg::ST_MUL1: begin
				m1_q <= x1 * pbf_pkg::MIX_C1;
			end
			pbf_pkg::ST_MUL2: begin
				dvd_q <= x3;
				rem_q <= '0;
			end
			pbf_pkg::ST_DIV: begin
				dvd_q <= dvd_nxt;
				rem_q <= rem_nxt;
			end
			pbf_pkg::ST_ADDR: begin
				addr_q <= st_raddr;
				bit_q  <= bit_abs[pbf_pkg::WORD_SEL_W-1:0];
				if (probe_oor) begin
					oor_q <= 1'b1;
				end
			end
			pbf_pkg::ST_RMW: begin
				if ((kind_q == pbf_pkg::KIND_QUERY) && !bit_set) begin
					present_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= {{(pbf_pkg::OUT_DATA_W - 2){1'b0}}, oor_q, present_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Page descriptor table
	pbf_ram #(
		.WIDTH (pbf_pkg::DESC_W),
		.DEPTH (pbf_pkg::PAGES)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (pbf_pkg::page_idx_t'(in_page)),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (pbf_pkg::page_idx_t'(in_page)),
		.rdata (tbl_rdata)
	);

	// Shared bit store
	pbf_ram #(
		.WIDTH (pbf_pkg::WORD_W),
		.DEPTH (pbf_pkg::STORE_WORDS)
	) u_store_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

endmodule

[rtl/pbf_check.sv]
// Port-level checks for the paged Bloom filter
module pbf_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [pbf_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [pbf_pkg::KIND_W-1:0]     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pbf_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A waiting input item holds its value
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input item changed while waiting");

	// Items are taken one at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accept");

	// Result padding stays zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[pbf_pkg::OUT_DATA_W-1:2] == '0))
		else $error("result padding not zero");

	// No result can appear right after an accept
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result too soon after accept");

endmodule

bind paged_bloom_filter_top pbf_check u_pbf_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
